>>> src/bfpa_pkg.sv
// Shared types and constants for the best-fit pool allocator.
// Used by bfpa_ctrl, bfpa_dp and the top level; depends on nothing.
`default_nettype none

package bfpa_pkg;

    // Header layout: 16-bit size, free flag above it
    localparam int SIZE_W     = 16;
    localparam int HDR_W      = 17;
    localparam int FREE_BIT   = 16;
    localparam int HDR_BYTES  = 3;
    // Walk offsets: pool (up to 64 KiB) plus header plus max block size
    localparam int WALK_W     = 18;
    localparam int BADDR_W    = 13;
    localparam int ADDR_W     = 13;

    typedef enum logic [1:0] {
        FUNC_ALLOC     = 2'd0,
        FUNC_FREE      = 2'd1,
        FUNC_FREE_LAST = 2'd2,
        FUNC_RESET     = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FAIL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_LAST_FREE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_CUR,
        RD_NX,
        RD_H
    } rd_sel_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_FREE_H,
        WR_MERGE,
        WR_SPLIT,
        WR_BEST_SIZE,
        WR_BEST_WHOLE,
        WR_APPEND,
        WR_LAST
    } wr_sel_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_BEST,
        RES_TOP
    } res_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic     load;
        logic     walk_init;
        logic     ev;
        logic     adv_ev;
        logic     adv_nx;
        logic     top_clr;
        logic     top_append;
        logic     top_last;
        logic     res;
        logic     push;
        rd_sel_t  rd;
        wr_sel_t  wr;
        res_sel_t rsel;
        status_t  st;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        func_t func;
        logic  req_bad;
        logic  free_null;
        logic  free_bad;
        logic  top_zero;
        logic  walk_more;
        logic  hdr_free;
        logic  nx_lt_top;
        logic  merge_ok;
        logic  found;
        logic  do_split;
        logic  append_ok;
        logic  last_free;
    } sts_t;

endpackage

`default_nettype wire

>>> src/bfpa_ram.sv
// Header store: one write port, one registered read port.
// No package dependencies.
`default_nettype none

module bfpa_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 17
) (
    input  wire logic          clk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> src/bfpa_dp.sv
// Allocator datapath: request registers, walk pointer, best-fit tracking,
// top offset, header store and result registers. Uses bfpa_pkg and bfpa_ram.
`default_nettype none

module bfpa_dp #(
    parameter int POOL_BYTES = 4096
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire bfpa_pkg::cmd_t                 cmd,
    input  wire logic [1:0]                     in_func,
    input  wire logic [bfpa_pkg::SIZE_W-1:0]    in_req,
    input  wire logic [bfpa_pkg::BADDR_W-1:0]   in_baddr,
    output bfpa_pkg::sts_t                      sts,
    output logic [bfpa_pkg::ADDR_W-1:0]         out_addr,
    output logic [1:0]                          out_status
);

    localparam int W  = bfpa_pkg::WALK_W;
    localparam int SW = bfpa_pkg::SIZE_W;
    localparam int IW = $clog2(POOL_BYTES);
    localparam int TW = $clog2(POOL_BYTES + 1);
    localparam logic [W-1:0] POOL_W = W'(POOL_BYTES);
    localparam logic [W-1:0] HDR    = W'(bfpa_pkg::HDR_BYTES);
    localparam logic [W-1:0] SMAX   = W'((1 << SW) - 1);

    // Request and walk registers
    bfpa_pkg::func_t       func_reg;
    logic [SW-1:0]         req_reg;
    logic [W-1:0]          hw_reg;
    logic [SW:0]           size_reg;
    logic [W-1:0]          cur_reg;
    logic [W-1:0]          nx_reg;
    logic [W-1:0]          best_reg;
    logic [SW-1:0]         bsize_reg;
    logic                  found_reg;
    logic [W-1:0]          last_reg;
    logic [SW-1:0]         s_reg;
    logic                  f_reg;
    logic [TW-1:0]         top_reg;
    logic [TW-1:0]         top_next;
    logic [bfpa_pkg::ADDR_W-1:0] res_addr_reg;
    bfpa_pkg::status_t     res_st_reg;
    logic [bfpa_pkg::ADDR_W-1:0] out_addr_reg;
    bfpa_pkg::status_t     out_st_reg;

    // RAM interface
    logic                        rd_en;
    logic [W-1:0]                rd_full;
    logic [bfpa_pkg::HDR_W-1:0]  rd_data;
    logic                        wr_en;
    logic [W-1:0]                wr_full;
    logic [bfpa_pkg::HDR_W-1:0]  wr_data;

    // Derived values
    logic [W-1:0]  top_w;
    logic [W-1:0]  req_w;
    logic [W-1:0]  size_w;
    logic [SW-1:0] hdr_s;
    logic          hdr_f;
    logic [W-1:0]  nx_w;
    logic [W-1:0]  merged_w;
    logic [W-1:0]  nh_w;
    logic [SW:0]   in_size;
    logic          better;

    assign top_w    = W'(top_reg);
    assign req_w    = W'(req_reg);
    assign size_w   = W'(size_reg);
    assign hdr_s    = rd_data[SW-1:0];
    assign hdr_f    = rd_data[bfpa_pkg::FREE_BIT];
    assign nx_w     = cur_reg + HDR + W'(hdr_s);
    assign merged_w = W'(s_reg) + HDR + W'(hdr_s);
    assign nh_w     = best_reg + HDR + size_w;
    assign in_size  = ({1'b0, in_req} + (SW+1)'(3)) & ~(SW+1)'(3);
    assign better   = hdr_f && (W'(hdr_s) >= size_w)
                      && (!found_reg || (hdr_s < bsize_reg));

    // Status to controller
    always_comb
    begin
        sts.func      = func_reg;
        sts.req_bad   = (req_reg == '0) || (req_w > POOL_W - HDR);
        sts.free_null = (hw_reg == '0);
        sts.free_bad  = (hw_reg < HDR) || (hw_reg - HDR >= POOL_W);
        sts.top_zero  = (top_reg == '0);
        sts.walk_more = (cur_reg < top_w);
        sts.hdr_free  = hdr_f;
        sts.nx_lt_top = (nx_w < top_w);
        sts.merge_ok  = hdr_f && (merged_w <= SMAX);
        sts.found     = found_reg;
        sts.do_split  = (W'(bsize_reg) > size_w + HDR) && (nh_w < POOL_W);
        sts.append_ok = (top_w + HDR + size_w <= POOL_W) && (size_w <= SMAX);
        sts.last_free = f_reg;
    end

    // Read address select
    always_comb
    begin
        rd_en = 1'b1;
        case (cmd.rd)
            bfpa_pkg::RD_CUR: rd_full = cur_reg;
            bfpa_pkg::RD_NX:  rd_full = nx_reg;
            bfpa_pkg::RD_H:   rd_full = hw_reg - HDR;
            default:
            begin
                rd_en   = 1'b0;
                rd_full = cur_reg;
            end
        endcase
    end

    // Header write select
    always_comb
    begin
        wr_en = 1'b1;
        case (cmd.wr)
            bfpa_pkg::WR_FREE_H:
            begin
                wr_full = hw_reg - HDR;
                wr_data = {1'b1, hdr_s};
            end
            bfpa_pkg::WR_MERGE:
            begin
                wr_full = cur_reg;
                wr_data = {1'b1, merged_w[SW-1:0]};
            end
            bfpa_pkg::WR_SPLIT:
            begin
                wr_full = nh_w;
                wr_data = {1'b1, bsize_reg - size_reg[SW-1:0] - SW'(3)};
            end
            bfpa_pkg::WR_BEST_SIZE:
            begin
                wr_full = best_reg;
                wr_data = {1'b0, size_reg[SW-1:0]};
            end
            bfpa_pkg::WR_BEST_WHOLE:
            begin
                wr_full = best_reg;
                wr_data = {1'b0, bsize_reg};
            end
            bfpa_pkg::WR_APPEND:
            begin
                wr_full = top_w;
                wr_data = {1'b0, size_reg[SW-1:0]};
            end
            bfpa_pkg::WR_LAST:
            begin
                wr_full = last_reg;
                wr_data = {1'b1, s_reg};
            end
            default:
            begin
                wr_en   = 1'b0;
                wr_full = cur_reg;
                wr_data = {1'b0, s_reg};
            end
        endcase
    end

    bfpa_ram #(
        .DEPTH (POOL_BYTES),
        .AW    (IW),
        .DW    (bfpa_pkg::HDR_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_full[IW-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_full[IW-1:0]),
        .wr_data (wr_data)
    );

    // Top offset
    always_comb
    begin
        top_next = top_reg;
        if (cmd.top_clr)
        begin
            top_next = '0;
        end
        else if (cmd.top_append)
        begin
            top_next = TW'(top_w + HDR + size_w);
        end
        else if (cmd.top_last)
        begin
            top_next = TW'(last_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= '0;
        end
        else
        begin
            top_reg <= top_next;
        end
    end

    // Request capture and header walk
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= bfpa_pkg::func_t'(in_func);
            req_reg  <= in_req;
            hw_reg   <= W'(in_baddr);
            size_reg <= in_size;
        end
        if (cmd.walk_init)
        begin
            cur_reg   <= '0;
            found_reg <= 1'b0;
        end
        if (cmd.ev)
        begin
            s_reg    <= hdr_s;
            f_reg    <= hdr_f;
            last_reg <= cur_reg;
            nx_reg   <= nx_w;
            if (func_reg == bfpa_pkg::FUNC_ALLOC && better)
            begin
                found_reg <= 1'b1;
                best_reg  <= cur_reg;
                bsize_reg <= hdr_s;
            end
        end
        if (cmd.adv_ev)
        begin
            cur_reg <= nx_w;
        end
        else if (cmd.adv_nx)
        begin
            cur_reg <= nx_reg;
        end
    end

    // Result and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.res)
        begin
            res_st_reg <= cmd.st;
            case (cmd.rsel)
                bfpa_pkg::RES_BEST: res_addr_reg <= bfpa_pkg::ADDR_W'(best_reg + HDR);
                bfpa_pkg::RES_TOP:  res_addr_reg <= bfpa_pkg::ADDR_W'(top_w + HDR);
                default:            res_addr_reg <= '0;
            endcase
        end
        if (cmd.push)
        begin
            out_addr_reg <= res_addr_reg;
            out_st_reg   <= res_st_reg;
        end
    end

    assign out_addr   = out_addr_reg;
    assign out_status = out_st_reg;

    // Checks
    a_top_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        W'(top_reg) <= POOL_W)
        else $error("top offset beyond pool");

    a_wr_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (wr_full < POOL_W))
        else $error("header write outside pool");

    a_walk_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd == bfpa_pkg::RD_CUR) |-> (cur_reg < top_w))
        else $error("walk read beyond top");

endmodule

`default_nettype wire

>>> src/bfpa_ctrl.sv
// Allocator controller: sequences the header walk, merge, split and
// result transfer. Uses bfpa_pkg; drives bfpa_dp through cmd_t / sts_t.
`default_nettype none

module bfpa_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire bfpa_pkg::sts_t sts,
    output bfpa_pkg::cmd_t      cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DISP     = 8'b0000_0010,
        S_FREE_WR  = 8'b0000_0100,
        S_WALK_RD  = 8'b0000_1000,
        S_WALK_EV  = 8'b0001_0000,
        S_NEXT_RD  = 8'b0010_0000,
        S_NEXT_EV  = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   split_reg, split_next;
    logic   valid_reg, valid_next;

    always_comb
    begin
        state_next = state_reg;
        split_next = split_reg;
        valid_next = valid_reg;
        cmd        = '0;
        in_ready   = 1'b0;

        if (valid_reg && out_ready)
        begin
            valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end

            S_DISP:
            begin
                case (sts.func)
                    bfpa_pkg::FUNC_ALLOC:
                    begin
                        if (sts.req_bad)
                        begin
                            cmd.res    = 1'b1;
                            cmd.st     = bfpa_pkg::ST_FAIL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.walk_init = 1'b1;
                            state_next    = S_WALK_RD;
                        end
                    end
                    bfpa_pkg::FUNC_FREE:
                    begin
                        if (sts.free_null)
                        begin
                            cmd.res    = 1'b1;
                            state_next = S_DONE;
                        end
                        else if (sts.free_bad)
                        begin
                            cmd.res    = 1'b1;
                            cmd.st     = bfpa_pkg::ST_FAIL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.rd     = bfpa_pkg::RD_H;
                            state_next = S_FREE_WR;
                        end
                    end
                    bfpa_pkg::FUNC_FREE_LAST:
                    begin
                        if (sts.top_zero)
                        begin
                            cmd.res    = 1'b1;
                            cmd.st     = bfpa_pkg::ST_EMPTY;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.walk_init = 1'b1;
                            state_next    = S_WALK_RD;
                        end
                    end
                    default:
                    begin
                        cmd.top_clr = 1'b1;
                        cmd.res     = 1'b1;
                        state_next  = S_DONE;
                    end
                endcase
            end

            // Set the free flag, then merge from the bottom
            S_FREE_WR:
            begin
                cmd.wr        = bfpa_pkg::WR_FREE_H;
                cmd.walk_init = 1'b1;
                state_next    = S_WALK_RD;
            end

            S_WALK_RD:
            begin
                if (split_reg)
                begin
                    // Second header write of a split
                    split_next = 1'b0;
                    cmd.wr     = bfpa_pkg::WR_BEST_SIZE;
                    cmd.res    = 1'b1;
                    cmd.rsel   = bfpa_pkg::RES_BEST;
                    state_next = S_DONE;
                end
                else if (sts.walk_more)
                begin
                    cmd.rd     = bfpa_pkg::RD_CUR;
                    state_next = S_WALK_EV;
                end
                else
                begin
                    cmd.res    = 1'b1;
                    state_next = S_DONE;
                    case (sts.func)
                        bfpa_pkg::FUNC_ALLOC:
                        begin
                            if (sts.found)
                            begin
                                if (sts.do_split)
                                begin
                                    cmd.wr     = bfpa_pkg::WR_SPLIT;
                                    cmd.res    = 1'b0;
                                    split_next = 1'b1;
                                    state_next = S_WALK_RD;
                                end
                                else
                                begin
                                    cmd.wr   = bfpa_pkg::WR_BEST_WHOLE;
                                    cmd.rsel = bfpa_pkg::RES_BEST;
                                end
                            end
                            else if (sts.append_ok)
                            begin
                                cmd.wr         = bfpa_pkg::WR_APPEND;
                                cmd.top_append = 1'b1;
                                cmd.rsel       = bfpa_pkg::RES_TOP;
                            end
                            else
                            begin
                                cmd.st = bfpa_pkg::ST_FAIL;
                            end
                        end
                        bfpa_pkg::FUNC_FREE_LAST:
                        begin
                            if (sts.last_free)
                            begin
                                cmd.st = bfpa_pkg::ST_LAST_FREE;
                            end
                            else
                            begin
                                cmd.wr       = bfpa_pkg::WR_LAST;
                                cmd.top_last = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd.st = bfpa_pkg::ST_OK;
                        end
                    endcase
                end
            end

            // Look at one header; during free, a free one may merge with its neighbor
            S_WALK_EV:
            begin
                cmd.ev = 1'b1;
                if (sts.func == bfpa_pkg::FUNC_FREE && sts.hdr_free && sts.nx_lt_top)
                begin
                    state_next = S_NEXT_RD;
                end
                else
                begin
                    cmd.adv_ev = 1'b1;
                    state_next = S_WALK_RD;
                end
            end

            S_NEXT_RD:
            begin
                cmd.rd     = bfpa_pkg::RD_NX;
                state_next = S_NEXT_EV;
            end

            S_NEXT_EV:
            begin
                if (sts.merge_ok)
                begin
                    cmd.wr = bfpa_pkg::WR_MERGE;
                end
                else
                begin
                    cmd.adv_nx = 1'b1;
                end
                state_next = S_WALK_RD;
            end

            S_DONE:
            begin
                if (!valid_reg || out_ready)
                begin
                    cmd.push   = 1'b1;
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            split_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            split_reg <= split_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg;

    // Checks
    a_split_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        split_reg |-> (state_reg == S_WALK_RD))
        else $error("split pending outside walk");

    a_push_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (!valid_reg || out_ready))
        else $error("result overwrites pending transfer");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_DISP))
        else $error("accepted request not dispatched");

endmodule

`default_nettype wire

>>> src/best_fit_pool_allocator.sv
// Top level of the best-fit pool allocator: controller plus datapath.
// Uses bfpa_pkg, bfpa_ctrl and bfpa_dp.
`default_nettype none

// One request at a time, one result per request. Allocate, free and
// free-last walk every block header below the top offset through the single
// read port of the header store: each block is read and then evaluated, and
// each merge attempt during free reads and evaluates the next header, around
// setup, write-back and result transfer. Reset-pool and rejected requests skip
// the walk. The next request is taken once the result sits in the output register.
module best_fit_pool_allocator #(
    parameter int POOL_BYTES = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // request_size[15:0], block_address[28:16], zero pad
    input  wire logic [1:0]  s_tuser,   // func[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // payload_address[12:0], status[14:13], zero pad
);

    bfpa_pkg::cmd_t cmd;
    bfpa_pkg::sts_t sts;
    logic [bfpa_pkg::ADDR_W-1:0] out_addr;
    logic [1:0]                  out_status;

    bfpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bfpa_dp #(
        .POOL_BYTES (POOL_BYTES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_func    (s_tuser),
        .in_req     (s_tdata[15:0]),
        .in_baddr   (s_tdata[28:16]),
        .sts        (sts),
        .out_addr   (out_addr),
        .out_status (out_status)
    );

    assign m_tdata = {1'b0, out_status, out_addr};

endmodule

`default_nettype wire
